// File: src/cdht_pkg.sv
// Shared types and constants for the command history table.
// No dependencies; every other file but cdht_ram imports this package.
package cdht_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int KEY_W   = 64;
  localparam int VOL_W   = 32;

  localparam logic [1:0] ACT_QUERY   = 2'd0;
  localparam logic [1:0] ACT_PENDING = 2'd1;
  localparam logic [1:0] ACT_DONE    = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] session;
    logic             done;
    logic [VOL_W-1:0] volume;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

endpackage

// File: src/cdht_in_if.sv
// Command word channel: valid/ready handshake with the command fields.
// Depends on cdht_pkg.
interface cdht_in_if import cdht_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       action;
  logic [KEY_W-1:0] cmd_key;
  logic [KEY_W-1:0] session_key;
  logic [VOL_W-1:0] volume_in;

  modport source (output valid, action, cmd_key, session_key, volume_in, input ready);
  modport sink   (input valid, action, cmd_key, session_key, volume_in, output ready);
endinterface

// File: src/cdht_out_if.sv
// Lookup result channel: valid/ready handshake with the matched entry fields.
// Depends on cdht_pkg.
interface cdht_out_if import cdht_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic             entry_done;
  logic [KEY_W-1:0] entry_session;
  logic [VOL_W-1:0] entry_volume;

  modport source (output valid, found, entry_done, entry_session, entry_volume, input ready);
  modport sink   (input valid, found, entry_done, entry_session, entry_volume, output ready);
endinterface

// File: src/command_dedup_history_table.sv
// Command history table: duplicate lookup over a record RAM, round-robin fill.
// Depends on cdht_pkg, cdht_in_if, cdht_out_if and cdht_ram.
//
//   channel | direction | word
//   in_ch   | sink      | action, cmd_key, session_key, volume_in
//   out_ch  | source    | found, entry_done, entry_session, entry_volume
//
// An empty-key word goes to the finish state; other words are scanned from index 0
// to the first match or the last entry, one record per cycle from the RAM port.
// Slot valid bits live in flops and clear at reset; no RAM clearing pass is needed.
// in_ch.ready is high only while the scan engine is free; the result register lets a
// new word enter while the last result waits. A stalled out_ch holds the finish state.
module command_dedup_history_table import cdht_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  cdht_in_if.sink     in_ch,
  cdht_out_if.source  out_ch
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

  state_t               state_r, state_nxt;
  idx_t                 cmp_idx_r, cmp_idx_nxt;
  idx_t                 wp_r, wp_nxt;
  logic [ENTRIES-1:0]   valid_r, valid_nxt;
  logic                 hit_r, hit_nxt;
  idx_t                 hit_idx_r, hit_idx_nxt;
  rec_t                 hit_rec_r, hit_rec_nxt;
  logic                 skip_r, skip_nxt;
  logic                 mark_r, mark_nxt;
  logic                 done_r, done_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [KEY_W-1:0]     sess_r, sess_nxt;
  logic [VOL_W-1:0]     vol_r, vol_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_found_r, out_found_nxt;
  logic                 out_done_r, out_done_nxt;
  logic [KEY_W-1:0]     out_sess_r, out_sess_nxt;
  logic [VOL_W-1:0]     out_vol_r, out_vol_nxt;

  logic  in_fire;
  logic  in_mark;
  logic  match;
  logic  last_idx;
  logic  finish_go;
  logic  ram_we;
  idx_t  ram_waddr;
  idx_t  ram_raddr;
  rec_t  ram_wrec;
  rec_t  ram_rrec;
  logic [REC_W-1:0] ram_rdata;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    case (in_ch.action) inside
      ACT_PENDING, ACT_DONE: in_mark = 1'b1;
      ACT_QUERY:             in_mark = 1'b0;
      default:               in_mark = 1'b0;
    endcase
  end

  assign ram_rrec  = rec_t'(ram_rdata);
  assign match     = valid_r[cmp_idx_r] && (ram_rrec.key == key_r);
  assign last_idx  = (cmp_idx_r == idx_t'(ENTRIES - 1));
  assign finish_go = (state_r == S_FINISH) && (!out_valid_r || out_ch.ready);
  assign ram_raddr = (state_r == S_SCAN) ? idx_t'(cmp_idx_r + 1'b1) : '0;

  assign ram_we          = finish_go && mark_r && !skip_r;
  assign ram_waddr       = hit_r ? hit_idx_r : wp_r;
  assign ram_wrec.key     = key_r;
  assign ram_wrec.session = sess_r;
  assign ram_wrec.done    = done_r;
  assign ram_wrec.volume  = done_r ? vol_r : '0;

  cdht_ram #(
    .WIDTH (REC_W),
    .DEPTH (ENTRIES)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wrec),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cmp_idx_nxt   = cmp_idx_r;
    wp_nxt        = wp_r;
    valid_nxt     = valid_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_rec_nxt   = hit_rec_r;
    skip_nxt      = skip_r;
    mark_nxt      = mark_r;
    done_nxt      = done_r;
    key_nxt       = key_r;
    sess_nxt      = sess_r;
    vol_nxt       = vol_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_found_nxt = out_found_r;
    out_done_nxt  = out_done_r;
    out_sess_nxt  = out_sess_r;
    out_vol_nxt   = out_vol_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          key_nxt     = in_ch.cmd_key;
          sess_nxt    = in_ch.session_key;
          vol_nxt     = in_ch.volume_in;
          mark_nxt    = in_mark;
          done_nxt    = (in_ch.action == ACT_DONE);
          skip_nxt    = (in_ch.cmd_key == '0);
          hit_nxt     = 1'b0;
          cmp_idx_nxt = '0;
          state_nxt   = (in_ch.cmd_key == '0) ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (match) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = cmp_idx_r;
          hit_rec_nxt = ram_rrec;
          state_nxt   = S_FINISH;
        end else if (last_idx) begin
          state_nxt   = S_FINISH;
        end else begin
          cmp_idx_nxt = idx_t'(cmp_idx_r + 1'b1);
        end
      end
      S_FINISH: begin
        if (finish_go) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = hit_r;
          out_done_nxt  = hit_r && hit_rec_r.done;
          out_sess_nxt  = hit_r ? hit_rec_r.session : '0;
          out_vol_nxt   = hit_r ? hit_rec_r.volume : '0;
          if (ram_we) begin
            valid_nxt[ram_waddr] = 1'b1;
            if (!hit_r) begin
              wp_nxt = (wp_r == idx_t'(ENTRIES - 1)) ? '0 : idx_t'(wp_r + 1'b1);
            end
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmp_idx_r   <= cmp_idx_nxt;
    hit_r       <= hit_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_rec_r   <= hit_rec_nxt;
    skip_r      <= skip_nxt;
    mark_r      <= mark_nxt;
    done_r      <= done_nxt;
    key_r       <= key_nxt;
    sess_r      <= sess_nxt;
    vol_r       <= vol_nxt;
    out_found_r <= out_found_nxt;
    out_done_r  <= out_done_nxt;
    out_sess_r  <= out_sess_nxt;
    out_vol_r   <= out_vol_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.found         = out_found_r;
  assign out_ch.entry_done    = out_done_r;
  assign out_ch.entry_session = out_sess_r;
  assign out_ch.entry_volume  = out_vol_r;

endmodule

// File: src/cdht_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cdht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/cdht_checker.sv
// Port-level checks for the command history table, bound to the top level.
// Depends on cdht_pkg and command_dedup_history_table.
module cdht_checker import cdht_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_found,
  input logic             out_done,
  input logic [KEY_W-1:0] out_sess,
  input logic [VOL_W-1:0] out_vol
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("command taken while a lookup is in flight");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (!out_done && out_sess == '0 && out_vol == '0))
    else $error("miss result carries nonzero entry fields");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_found) && $stable(out_done)
      && $stable(out_sess) && $stable(out_vol)))
    else $error("stalled result word changed");

endmodule

bind command_dedup_history_table cdht_checker u_cdht_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_found (out_ch.found),
  .out_done  (out_ch.entry_done),
  .out_sess  (out_ch.entry_session),
  .out_vol   (out_ch.entry_volume)
);

// File: tb/command_dedup_history_table_tb.sv
`timescale 1ns / 1ps
// Testbench for command_dedup_history_table: directed and random command words
// with a local history predictor and an in-order result scoreboard.
// Depends on cdht_pkg, cdht_in_if, cdht_out_if and the table RTL.
module command_dedup_history_table_tb import cdht_pkg::*; ();

  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam int         STALL_LIMIT = 1000;
  localparam int         KEY_POOL    = 24;
  localparam int         RAND_ITEMS  = 2000;

  typedef struct packed {
    logic             found;
    logic             done;
    logic [KEY_W-1:0] session;
    logic [VOL_W-1:0] volume;
  } lookup_res_t;

  logic clk = 1'b0;
  logic rst_n;

  cdht_in_if  in_ch ();
  cdht_out_if out_ch ();

  command_dedup_history_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic             hist_valid [ENTRIES];
  logic [KEY_W-1:0] hist_key   [ENTRIES];
  logic [KEY_W-1:0] hist_sess  [ENTRIES];
  logic             hist_done  [ENTRIES];
  logic [VOL_W-1:0] hist_vol   [ENTRIES];
  int               fill_ptr;
  int               fill_cnt;

  lookup_res_t pending_lookups[$];
  int          err_cnt;
  int          hit_cnt;
  int          miss_cnt;
  int          empty_cnt;
  int          checked_cnt;
  int          idle_cycles;
  int          out_stall;
  bit          burst_mode;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic lookup_res_t history_apply(input logic [1:0] act,
                                                input logic [KEY_W-1:0] key,
                                                input logic [KEY_W-1:0] sess,
                                                input logic [VOL_W-1:0] vol);
    lookup_res_t res;
    int          idx;
    res = '0;
    idx = -1;
    if (key == '0) begin
      empty_cnt++;
      return res;
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hist_valid[i] && hist_key[i] == key) idx = i;
    end
    if (idx >= 0) begin
      hit_cnt++;
      res.found   = 1'b1;
      res.done    = hist_done[idx];
      res.session = hist_sess[idx];
      res.volume  = hist_vol[idx];
    end else begin
      miss_cnt++;
    end
    if (act == ACT_PENDING || act == ACT_DONE) begin
      if (idx < 0) begin
        idx      = fill_ptr;
        fill_ptr = (fill_ptr + 1) % ENTRIES;
        fill_cnt++;
      end
      hist_valid[idx] = 1'b1;
      hist_key[idx]   = key;
      hist_sess[idx]  = sess;
      hist_done[idx]  = (act == ACT_DONE);
      hist_vol[idx]   = (act == ACT_DONE) ? vol : '0;
    end
    return res;
  endfunction

  task automatic send_cmd(input logic [1:0] act, input logic [KEY_W-1:0] key,
                          input logic [KEY_W-1:0] sess, input logic [VOL_W-1:0] vol);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.cmd_key     <= key;
    in_ch.session_key <= sess;
    in_ch.volume_in   <= vol;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_lookups.push_back(history_apply(act, key, sess, vol));
    @(negedge clk);
  endtask

  // result side: hold ready low for a random stall before taking each word, none in burst mode
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_ch.ready <= 1'b0;
      out_stall--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    lookup_res_t exp_res;
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("command_dedup_history_table_tb NOT OK");
        $finish;
      end
      if (out_ch.valid && out_ch.ready) begin
        out_stall = burst_mode ? 0 : $urandom_range(0, 7);
        if (pending_lookups.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual found=%b",
                   $time, out_ch.found);
          err_cnt++;
        end else begin
          exp_res = pending_lookups.pop_front();
          checked_cnt++;
          if (out_ch.found !== exp_res.found) begin
            $display("%0t: found expected %b actual %b", $time, exp_res.found, out_ch.found);
            err_cnt++;
          end
          if (out_ch.entry_done !== exp_res.done) begin
            $display("%0t: entry_done expected %b actual %b",
                     $time, exp_res.done, out_ch.entry_done);
            err_cnt++;
          end
          if (out_ch.entry_session !== exp_res.session) begin
            $display("%0t: entry_session expected %h actual %h",
                     $time, exp_res.session, out_ch.entry_session);
            err_cnt++;
          end
          if (out_ch.entry_volume !== exp_res.volume) begin
            $display("%0t: entry_volume expected %h actual %h",
                     $time, exp_res.volume, out_ch.entry_volume);
            err_cnt++;
          end
        end
      end
    end
  end

  task automatic test_empty_key();
    send_cmd(ACT_QUERY,   '0, '1, '1);
    send_cmd(ACT_PENDING, '0, '1, '1);
    send_cmd(ACT_DONE,    '0, '1, '1);
    send_cmd(ACT_UNUSED,  '0, '0, '0);
  endtask

  task automatic test_basic_marks();
    logic [KEY_W-1:0] key_hi;
    logic [KEY_W-1:0] key_lo;
    key_hi = '1;
    key_lo = 64'd1;
    send_cmd(ACT_QUERY,   key_hi, 64'h0123_4567_89AB_CDEF, 32'h1234_5678);
    send_cmd(ACT_PENDING, key_hi, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(ACT_QUERY,   key_hi, '0, '0);
    send_cmd(ACT_DONE,    key_hi, 64'hA5A5_5A5A_A5A5_5A5A, 32'hFFFF_FFFF);
    send_cmd(ACT_UNUSED,  key_hi, '0, '0);
    send_cmd(ACT_PENDING, key_hi, '0, 32'hDEAD_BEEF);
    send_cmd(ACT_DONE,    key_lo, '0, '0);
    send_cmd(ACT_QUERY,   key_lo, '1, '1);
    send_cmd(ACT_QUERY,   64'h8000_0000_0000_0000, '0, '0);
  endtask

  task automatic test_random_traffic();
    logic [KEY_W-1:0] pool [KEY_POOL];
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] sess;
    logic [VOL_W-1:0] vol;
    int               pick;
    for (int i = 0; i < KEY_POOL; i++) begin
      pool[i] = {$urandom, $urandom};
      if (pool[i] == '0) pool[i] = 64'd2;
    end
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 250 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        key = '0;
      end else if (pick < 15) begin
        key = {$urandom, $urandom};
      end else begin
        key = pool[$urandom_range(0, KEY_POOL - 1)];
      end
      sess = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0:       vol = '0;
        1:       vol = '1;
        default: vol = $urandom;
      endcase
      send_cmd(2'($urandom_range(0, 3)), key, sess, vol);
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.action      = ACT_QUERY;
    in_ch.cmd_key     = '0;
    in_ch.session_key = '0;
    in_ch.volume_in   = '0;
    out_ch.ready      = 1'b0;
    out_stall         = 0;
    burst_mode        = 1'b0;
    err_cnt           = 0;
    hit_cnt           = 0;
    miss_cnt          = 0;
    empty_cnt         = 0;
    checked_cnt       = 0;
    idle_cycles       = 0;
    fill_ptr          = 0;
    fill_cnt          = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      hist_valid[i] = 1'b0;
      hist_key[i]   = '0;
      hist_sess[i]  = '0;
      hist_done[i]  = 1'b0;
      hist_vol[i]   = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_key();
    test_basic_marks();
    test_random_traffic();
    in_ch.valid <= 1'b0;

    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (2 + ENTRIES + 8) @(posedge clk);

    $display("checked %0d result words: %0d hits, %0d misses, %0d empty keys",
             checked_cnt, hit_cnt, miss_cnt, empty_cnt);
    $display("history table took %0d round-robin slot fills", fill_cnt);
    if (err_cnt == 0) begin
      $display("command_dedup_history_table_tb OK");
    end else begin
      $display("command_dedup_history_table_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/cdht_pkg.sv
src/cdht_in_if.sv
src/cdht_out_if.sv
src/cdht_ram.sv
src/command_dedup_history_table.sv
src/cdht_checker.sv
tb/command_dedup_history_table_tb.sv
